>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are disabled while rst is high.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

`define ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("next-cycle check violated");

`endif

>>> sv/r2nv_pkg.sv
package r2nv_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CH_W       = 8;
  localparam int SUM_W      = CH_W + 1;
  localparam int PAIR_W     = 3 * SUM_W;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 13;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] WIDTH_RESET  = 12'd1920;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd1080;

  localparam logic [15:0] Y_COEF_R = 16'd47;
  localparam logic [15:0] Y_COEF_G = 16'd157;
  localparam logic [15:0] Y_COEF_B = 16'd16;
  localparam logic [15:0] RND_HALF = 16'd128;
  localparam logic [7:0]  Y_OFFSET = 8'd16;
  localparam logic [7:0]  Y_MAX    = 8'd235;

  localparam logic signed [15:0] U_COEF_R = -16'sd26;
  localparam logic signed [15:0] U_COEF_G = -16'sd87;
  localparam logic signed [15:0] U_COEF_B = 16'sd112;
  localparam logic signed [15:0] V_COEF_R = 16'sd112;
  localparam logic signed [15:0] V_COEF_G = -16'sd102;
  localparam logic signed [15:0] V_COEF_B = -16'sd10;
  localparam logic signed [15:0] C_ROUND  = 16'sd128;
  localparam logic signed [15:0] C_OFFSET = 16'sd128;
  localparam logic signed [15:0] C_MIN    = 16'sd16;
  localparam logic signed [15:0] C_MAX    = 16'sd240;

  typedef struct packed {
    logic [CH_W-1:0]  luma;
    logic             chroma;
    logic             last;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
  } front_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [PAIR_AW-1:0] addr;
    logic [PAIR_W-1:0]  wr_data;
  } line_req_t;

endpackage

>>> sv/r2nv_line_store.sv
module r2nv_line_store import r2nv_pkg::*; (
  input  logic              clk,
  input  line_req_t         req,
  output logic [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0] mem [PAIR_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

>>> sv/r2nv_front.sv
`include "assert_macros.svh"

module r2nv_front import r2nv_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            accept,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  input  logic [FW_W-1:0] frame_width,
  input  logic [FH_W-1:0] frame_height,
  output line_req_t       mem_req,
  output logic            s1_valid,
  output front_t          s1_data
);

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [CH_W-1:0]  left_r;
  logic [CH_W-1:0]  left_g;
  logic [CH_W-1:0]  left_b;

  logic [FW_W-1:0]  width_even;
  logic [FW_W-1:0]  width_eff;
  logic [FH_W-1:0]  height_even;
  logic [FH_W-1:0]  height_eff;
  logic             row_end;
  logic             frame_end;
  logic [15:0]      y_sum;
  logic [CH_W-1:0]  y_val;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  front_t           s1_next;

  always_comb begin
    width_even = {frame_width[FW_W-1:1], 1'b0};
    width_eff  = width_even;
    if (width_even < FW_W'(2)) begin
      width_eff = FW_W'(2);
    end else if (width_even > FW_W'(MAX_WIDTH)) begin
      width_eff = FW_W'(MAX_WIDTH);
    end
    height_even = {frame_height[FH_W-1:1], 1'b0};
    height_eff  = height_even;
    if (height_even < FH_W'(2)) begin
      height_eff = FH_W'(2);
    end else if (height_even > FH_W'(MAX_HEIGHT)) begin
      height_eff = FH_W'(MAX_HEIGHT);
    end
    row_end   = ({1'b0, column_count} + FW_W'(1)) >= width_eff;
    frame_end = ({1'b0, row_count} + FH_W'(1)) >= height_eff;
  end

  always_comb begin
    y_sum = Y_COEF_R * 16'(red) + Y_COEF_G * 16'(green) + Y_COEF_B * 16'(blue) + RND_HALF;
    y_val = y_sum[15:8] + Y_OFFSET;
    if (y_val > Y_MAX) begin
      y_val = Y_MAX;
    end
  end

  always_comb begin
    sum_r = {1'b0, red} + {1'b0, left_r};
    sum_g = {1'b0, green} + {1'b0, left_g};
    sum_b = {1'b0, blue} + {1'b0, left_b};

    mem_req.addr    = column_count[COL_W-1:1];
    mem_req.wr_data = {sum_r, sum_g, sum_b};
    mem_req.wr_en   = accept && column_count[0] && !row_count[0];
    mem_req.rd_en   = accept && column_count[0] && row_count[0];

    s1_next.luma   = y_val;
    s1_next.chroma = column_count[0] && row_count[0];
    s1_next.last   = row_end && frame_end;
    s1_next.sum_r  = sum_r;
    s1_next.sum_g  = sum_g;
    s1_next.sum_b  = sum_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_r       <= '0;
      left_g       <= '0;
      left_b       <= '0;
    end else if (accept) begin
      if (!column_count[0]) begin
        left_r <= red;
        left_g <= green;
        left_b <= blue;
      end
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_data <= s1_next;
    end
  end

  `ASSERT_ALWAYS(a_line_single_access, !(mem_req.rd_en && mem_req.wr_en))
  `ASSERT_NEXT(a_row_wrap, accept && row_end, column_count == '0)

endmodule

>>> sv/r2nv_chroma.sv
`include "assert_macros.svh"

module r2nv_chroma import r2nv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              s1_valid,
  input  front_t            s1_data,
  input  logic [PAIR_W-1:0] upper,
  output logic              res_valid,
  output logic [CH_W-1:0]   luma,
  output logic              chroma_valid,
  output logic [CH_W-1:0]   cb,
  output logic [CH_W-1:0]   cr,
  output logic              frame_last
);

  logic                s2_valid;
  logic [CH_W-1:0]     s2_luma;
  logic                s2_chroma;
  logic                s2_last;
  logic signed [15:0]  s2_u;
  logic signed [15:0]  s2_v;

  logic [SUM_W:0]      quad_r;
  logic [SUM_W:0]      quad_g;
  logic [SUM_W:0]      quad_b;
  logic signed [15:0]  avg_r;
  logic signed [15:0]  avg_g;
  logic signed [15:0]  avg_b;
  logic signed [15:0]  u_next;
  logic signed [15:0]  v_next;
  logic signed [15:0]  u_level;
  logic signed [15:0]  v_level;
  logic [CH_W-1:0]     cb_next;
  logic [CH_W-1:0]     cr_next;

  always_comb begin
    quad_r = {1'b0, s1_data.sum_r} + {1'b0, upper[PAIR_W-1 -: SUM_W]};
    quad_g = {1'b0, s1_data.sum_g} + {1'b0, upper[2*SUM_W-1 -: SUM_W]};
    quad_b = {1'b0, s1_data.sum_b} + {1'b0, upper[SUM_W-1:0]};
    avg_r  = $signed(16'(quad_r[SUM_W:2]));
    avg_g  = $signed(16'(quad_g[SUM_W:2]));
    avg_b  = $signed(16'(quad_b[SUM_W:2]));
    u_next = U_COEF_R * avg_r + U_COEF_G * avg_g + U_COEF_B * avg_b + C_ROUND;
    v_next = V_COEF_R * avg_r + V_COEF_G * avg_g + V_COEF_B * avg_b + C_ROUND;
  end

  always_comb begin
    u_level = (s2_u >>> 8) + C_OFFSET;
    v_level = (s2_v >>> 8) + C_OFFSET;
    if (u_level < C_MIN) begin
      u_level = C_MIN;
    end else if (u_level > C_MAX) begin
      u_level = C_MAX;
    end
    if (v_level < C_MIN) begin
      v_level = C_MIN;
    end else if (v_level > C_MAX) begin
      v_level = C_MAX;
    end
    cb_next = s2_chroma ? u_level[CH_W-1:0] : '0;
    cr_next = s2_chroma ? v_level[CH_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_luma      <= s1_data.luma;
      s2_chroma    <= s1_data.chroma;
      s2_last      <= s1_data.last;
      s2_u         <= u_next;
      s2_v         <= v_next;
      luma         <= s2_luma;
      chroma_valid <= s2_chroma;
      frame_last   <= s2_last;
      cb           <= cb_next;
      cr           <= cr_next;
    end
  end

  `ASSERT_ALWAYS(a_chroma_range, !(res_valid && chroma_valid) || (cb >= 8'd16 && cb <= 8'd240 && cr >= 8'd16 && cr <= 8'd240))
  `ASSERT_ALWAYS(a_chroma_zero, !res_valid || chroma_valid || (cb == '0 && cr == '0))

endmodule

>>> sv/rgba_to_nv12_bt709_converter_top.sv
// RGB to NV12 converter, BT.709 limited range.
// Pixel channel: red, green and blue arrive in raster order with pix_valid; a
// transaction takes place on a clock edge where pix_valid is high and pix_stall is low.
// Result channel: one result per pixel with luma, frame_last and, on the
// bottom-right pixel of each 2x2 block, chroma_valid with cb and cr.
// Configuration: cfg_valid with cfg_index and cfg_data writes frame_width (index 0)
// or frame_height (index 1); cfg_ready is always high, other indexes are ignored.
// Throughput is one pixel per clock while pix_stall is low. An accepted pixel is
// registered into the front stage and the line store read stage, then into the chroma
// multiply stage, then into the output register.
// The line store holds the upper row's pair sums; it is written on even rows and read
// on odd rows at the same column pair.
// Reset sets the frame size to 1920x1080 and clears the position counters; the line
// store is not cleared, and every entry is written before it is read.
// When a result is held and res_stall is high, the whole pipeline freezes and
// pix_stall rises in the same cycle until the result is taken.
module rgba_to_nv12_bt709_converter_top import r2nv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [CH_W-1:0]   luma,
  output logic              chroma_valid,
  output logic [CH_W-1:0]   cb,
  output logic [CH_W-1:0]   cr,
  output logic              frame_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic              en;
  logic              accept;
  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  line_req_t         mem_req;
  logic [PAIR_W-1:0] upper;
  logic              s1_valid;
  front_t            s1_data;

  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;
  assign accept    = pix_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[FW_W-1:0];
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  r2nv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .accept       (accept),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .mem_req      (mem_req),
    .s1_valid     (s1_valid),
    .s1_data      (s1_data)
  );

  r2nv_line_store u_line_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (upper)
  );

  r2nv_chroma u_chroma (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .s1_valid     (s1_valid),
    .s1_data      (s1_data),
    .upper        (upper),
    .res_valid    (res_valid),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .cb           (cb),
    .cr           (cr),
    .frame_last   (frame_last)
  );

endmodule
